// File: rtl/core/reply_packet_checker_unit_defines.svh
// Assertion macros shared by the reply packet checker modules.
`ifndef REPLY_PACKET_CHECKER_UNIT_DEFINES_SVH
`define REPLY_PACKET_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reply packet checker: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reply packet checker: next-cycle check failed");

`endif

// File: rtl/core/rpc_pkg.sv
// Shared types and constants of the reply packet checker.
package rpc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_HEADER   = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SHOW,
    BK_LOAD
  } bk_state_t;

  localparam int unsigned CNT_W = 6;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] POS_ID      = 8'd2;
  localparam logic [7:0] POS_LEN     = 8'd3;
  localparam logic [7:0] POS_INS     = 8'd4;
  localparam logic [7:0] POS_PARAM   = 8'd5;
  localparam logic [7:0] IDX_MAX     = 8'd255;
  localparam logic [8:0] LEN_OVRHD   = 9'd4;
  localparam logic [8:0] MIN_COUNT   = 9'd2;
  localparam logic [7:0] LEN_FIXED   = 8'd2;

  // One checked packet, as handed from front to back
  typedef struct packed {
    status_t            status;
    logic [7:0]         packet_id;
    logic [7:0]         instruction;
    logic [CNT_W-1:0]   param_count;
    logic               bank;
  } desc_t;

endpackage

// File: rtl/core/rpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/rpc_queue.sv
// Two-entry descriptor queue between the packet front end and the result back end.
`include "reply_packet_checker_unit_defines.svh"
module rpc_queue
  import rpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  not_empty,
  output logic  full,
  output logic  wr_bank
);

  desc_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed descriptor, tagged with the bank it filled
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head      = slot_r[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign wr_bank   = wr_ptr_r;

  `RPC_ASSERT_IMPL(a_no_push_full, push, !full)
  `RPC_ASSERT_IMPL(a_no_pop_empty, pop, not_empty)
  `RPC_ASSERT_IMPL(a_count_range, 1'b1, count_r != 2'd3)
  `RPC_ASSERT_IMPL(a_ptr_match, count_r == 2'd0 || count_r == 2'd2, wr_ptr_r == rd_ptr_r)

endmodule

// File: rtl/core/rpc_front.sv
// Front end: takes packet words, tracks position, sum and header, stores parameters.
module rpc_front
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_PARAMS = 32,
  parameter int unsigned ADDR_W     = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_end_of_packet,
  input  logic              q_full,
  input  logic              q_bank,
  output logic              q_push,
  output desc_t             q_desc,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [7:0]        ram_wr_data
);

  localparam int unsigned IDX_W    = ADDR_W - 1;
  localparam logic [8:0]  LEN_TOP  = 9'(MAX_PARAMS + 2);
  localparam logic [8:0]  PARAM_END = 9'(MAX_PARAMS + 5);

  logic [7:0] byte_index_r, byte_index_nxt;
  logic       header_good_r, header_good_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] declared_length_r;
  logic [7:0] held_id_r;
  logic [7:0] held_instruction_r;

  logic       accept;
  logic       hdr_ok;
  logic [8:0] count;
  logic [7:0] param_idx;
  status_t    status;

  assign accept   = in_valid & in_ready;
  assign in_ready = !q_full;

  // Classify the current word against the packet so far
  always_comb begin
    hdr_ok    = header_good_r & !((byte_index_r < POS_ID) && (in_rx_byte != HDR_BYTE));
    count     = {1'b0, byte_index_r} + 9'd1;
    param_idx = byte_index_r - POS_PARAM;
    if (count < MIN_COUNT || !hdr_ok) begin
      status = ST_HEADER;
    end else if (count < LEN_OVRHD || declared_length_r < LEN_FIXED ||
                 {1'b0, declared_length_r} > LEN_TOP ||
                 {1'b0, declared_length_r} != (count - LEN_OVRHD)) begin
      status = ST_LENGTH;
    end else if (~running_sum_r != in_rx_byte) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_GOOD;
    end
  end

  // Hand a finished packet to the back end
  always_comb begin
    q_push             = accept & in_end_of_packet;
    q_desc.status      = status;
    q_desc.bank        = q_bank;
    if (status == ST_GOOD) begin
      q_desc.packet_id   = held_id_r;
      q_desc.instruction = held_instruction_r;
      q_desc.param_count = CNT_W'(declared_length_r - LEN_FIXED);
    end else begin
      q_desc.packet_id   = 8'd0;
      q_desc.instruction = 8'd0;
      q_desc.param_count = '0;
    end
  end

  // Store parameter words into the current bank
  assign ram_wr_en   = accept & !in_end_of_packet & (byte_index_r >= POS_PARAM) &
                       ({1'b0, byte_index_r} < PARAM_END);
  assign ram_wr_addr = {q_bank, param_idx[IDX_W-1:0]};
  assign ram_wr_data = in_rx_byte;

  // Advance per-packet tracking state
  always_comb begin
    byte_index_nxt  = byte_index_r;
    header_good_nxt = header_good_r;
    running_sum_nxt = running_sum_r;
    if (accept) begin
      if (in_end_of_packet) begin
        byte_index_nxt  = 8'd0;
        header_good_nxt = 1'b1;
        running_sum_nxt = 8'd0;
      end else begin
        header_good_nxt = hdr_ok;
        if (byte_index_r >= POS_ID) begin
          running_sum_nxt = running_sum_r + in_rx_byte;
        end
        if (byte_index_r != IDX_MAX) begin
          byte_index_nxt = byte_index_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r  <= 8'd0;
      header_good_r <= 1'b1;
      running_sum_r <= 8'd0;
    end else begin
      byte_index_r  <= byte_index_nxt;
      header_good_r <= header_good_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

  // Capture the fixed fields by position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      declared_length_r  <= 8'd0;
      held_id_r          <= 8'd0;
      held_instruction_r <= 8'd0;
    end else if (accept && !in_end_of_packet) begin
      if (byte_index_r == POS_ID) begin
        held_id_r <= in_rx_byte;
      end
      if (byte_index_r == POS_LEN) begin
        declared_length_r <= in_rx_byte;
      end
      if (byte_index_r == POS_INS) begin
        held_instruction_r <= in_rx_byte;
      end
    end
  end

endmodule

// File: rtl/core/rpc_back.sv
// Back end: turns queued packet descriptors into status and parameter result words.
`include "reply_packet_checker_unit_defines.svh"
module rpc_back
  import rpc_pkg::*;
#(
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  desc_t             q_head,
  output logic              q_pop,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  logic [7:0]        ram_rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [7:0]        out_packet_id,
  output logic [7:0]        out_instruction,
  output logic [CNT_W-1:0]  out_param_count,
  output logic [7:0]        out_param_byte,
  output logic              out_is_param,
  output logic              out_last
);

  localparam int unsigned IDX_W = ADDR_W - 1;

  bk_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] k_inc;
  logic [CNT_W-1:0] rd_idx;
  logic             ld_status;
  logic             ld_param;

  status_t          out_status_r;
  logic [7:0]       out_packet_id_r;
  logic [7:0]       out_instruction_r;
  logic [CNT_W-1:0] out_param_count_r;
  logic [7:0]       out_param_byte_r;
  logic             out_is_param_r;
  logic             out_last_r;

  assign k_inc = k_r + CNT_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = BK_SHOW;
        end
      end
      BK_SHOW: begin
        if (out_ready) begin
          state_nxt = out_last_r ? BK_IDLE : BK_LOAD;
        end
      end
      BK_LOAD: begin
        state_nxt = BK_SHOW;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    ld_status = 1'b0;
    ld_param  = 1'b0;
    out_valid = 1'b0;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        ld_status = q_not_empty;
      end
      BK_SHOW: begin
        out_valid = 1'b1;
        q_pop     = out_ready & out_last_r;
      end
      BK_LOAD: begin
        ld_param = 1'b1;
      end
      default: begin
        ld_status = 1'b0;
      end
    endcase
  end

  // Prefetch the next parameter word from the packet's bank
  assign rd_idx      = ld_status ? '0 : k_inc;
  assign ram_rd_en   = ld_status | ld_param;
  assign ram_rd_addr = {q_head.bank, rd_idx[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load the result register and the parameter counter
  always_ff @(posedge clk) begin
    if (ld_status) begin
      k_r               <= '0;
      out_status_r      <= q_head.status;
      out_packet_id_r   <= q_head.packet_id;
      out_instruction_r <= q_head.instruction;
      out_param_count_r <= q_head.param_count;
      out_param_byte_r  <= 8'd0;
      out_is_param_r    <= 1'b0;
      out_last_r        <= (q_head.status != ST_GOOD) || (q_head.param_count == '0);
    end else if (ld_param) begin
      k_r              <= k_inc;
      out_param_byte_r <= ram_rd_data;
      out_is_param_r   <= 1'b1;
      out_last_r       <= (k_inc == out_param_count_r);
    end
  end

  assign out_status      = out_status_r;
  assign out_packet_id   = out_packet_id_r;
  assign out_instruction = out_instruction_r;
  assign out_param_count = out_param_count_r;
  assign out_param_byte  = out_param_byte_r;
  assign out_is_param    = out_is_param_r;
  assign out_last        = out_last_r;

  `RPC_ASSERT_IMPL(a_param_only_good, out_valid && out_is_param_r, out_status_r == ST_GOOD)
  `RPC_ASSERT_IMPL(a_bad_is_single, out_valid && out_status_r != ST_GOOD, out_last_r && !out_is_param_r)
  `RPC_ASSERT_NEXT(a_load_then_show, state_r == BK_LOAD, state_r == BK_SHOW)
  `RPC_ASSERT_IMPL(a_pop_needs_head, q_pop, q_not_empty)

endmodule

// File: rtl/core/reply_packet_checker_unit.sv
// Reply packet checker: top level joining front end, descriptor queue, back end and RAM.
// The front end takes one packet word per cycle while in_ready is high and checks the
// header, the declared length against the word count, and the inverted checksum on the
// word flagged end_of_packet. Each packet yields one status word and, if good, one word per
// parameter, each held until taken; the next word comes from the registered read of the
// parameter RAM, prefetched while the previous word is shown. Parameters go to one of two
// RAM banks, and a two-entry descriptor queue lets a new packet come in while the previous
// one drains; in_ready drops only while two checked packets still wait to be emitted.
// MAX_PARAMS sets the parameter buffer depth per bank; a packet declaring more parameters
// is reported as a wrong length. No clearing pass after reset.
module reply_packet_checker_unit
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_PARAMS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_end_of_packet,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_packet_id,
  output logic [7:0] out_instruction,
  output logic [5:0] out_param_count,
  output logic [7:0] out_param_byte,
  output logic       out_is_param,
  output logic       out_last
);

  localparam int unsigned IDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;

  logic              q_push;
  desc_t             q_desc;
  logic              q_pop;
  desc_t             q_head;
  logic              q_not_empty;
  logic              q_full;
  logic              q_bank;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  // Accept and check packet words
  rpc_front #(
    .MAX_PARAMS (MAX_PARAMS),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_packet (in_end_of_packet),
    .q_full           (q_full),
    .q_bank           (q_bank),
    .q_push           (q_push),
    .q_desc           (q_desc),
    .ram_wr_en        (ram_wr_en),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data)
  );

  // Hold checked packets between the two sides
  rpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full),
    .wr_bank   (q_bank)
  );

  // Two banks of parameter storage
  rpc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_param_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Emit result words
  rpc_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_packet_id   (out_packet_id),
    .out_instruction (out_instruction),
    .out_param_count (out_param_count),
    .out_param_byte  (out_param_byte),
    .out_is_param    (out_is_param),
    .out_last        (out_last)
  );

endmodule
